### hdl/ovls_pkg.sv
// Shared constants, codes and types of the ordered value list store.
package ovls_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 7;
    localparam int S_TDATA_W    = 32;
    localparam int S_TUSER_W    = 8;
    localparam int M_TDATA_W    = 80;

    localparam logic signed [VALUE_W-1:0] INT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] NEG_ONE = '1;

    // operation codes on the kind field; the unused code acts as a search
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic                       clear;
        logic                       en;
        logic signed [VALUE_W-1:0]  data;
    } cmp_ctl_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  top;
        logic signed [VALUE_W-1:0]  runner;
        logic                       sorted;
    } stats_t;

endpackage

### hdl/ovls_cmp_unit.sv
// Compare unit: running maximum, runner-up and order check, one entry per cycle.
module ovls_cmp_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  ovls_pkg::cmp_ctl_t ctl,
    output ovls_pkg::stats_t   stats
);
    import ovls_pkg::*;

    logic signed [VALUE_W-1:0] top_reg, top_next;
    logic signed [VALUE_W-1:0] runner_reg, runner_next;
    logic signed [VALUE_W-1:0] prev_reg, prev_next;
    logic                      sorted_reg, sorted_next;
    logic                      first_reg, first_next;

    always_comb begin
        top_next    = top_reg;
        runner_next = runner_reg;
        prev_next   = prev_reg;
        sorted_next = sorted_reg;
        first_next  = first_reg;
        if (ctl.clear) begin
            top_next    = INT_MIN;
            runner_next = INT_MIN;
            sorted_next = 1'b1;
            first_next  = 1'b1;
        end else if (ctl.en) begin
            if (ctl.data > top_reg) begin
                runner_next = top_reg;
                top_next    = ctl.data;
            end else if ((ctl.data > runner_reg) && (ctl.data != top_reg)) begin
                runner_next = ctl.data;
            end
            if (!first_reg && (prev_reg > ctl.data)) begin
                sorted_next = 1'b0;
            end
            prev_next  = ctl.data;
            first_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sorted_reg <= 1'b1;
            first_reg  <= 1'b1;
        end else begin
            sorted_reg <= sorted_next;
            first_reg  <= first_next;
        end
        top_reg    <= top_next;
        runner_reg <= runner_next;
        prev_reg   <= prev_next;
    end

    assign stats.top    = top_reg;
    assign stats.runner = runner_reg;
    assign stats.sorted = sorted_reg;

endmodule

### hdl/ordered_value_list_store_top.sv
// Top level: entry memory, scan sequencer and result register.
//
//  channel | dir | payload
//  s_      | in  | tuser[1:0] kind, tdata[31:0] value
//  m_      | out | tdata: status, entry_count, largest_value, second_value, in_order
//
// A word is handled in order: the accept, one read issue per entry scanned through the single
// read port, the registered read data, the scan end being seen, and the posting of the result.
// The entries scanned are the count before the word, one more for an insert that is stored.
// Empty delete or search skips the scan. Reset (aresetn, synchronous) empties the list.
// s_tready is high only between items; a held result does not block the next item's work,
// only its final write into the result register.
module ordered_value_list_store_top #(
    parameter int CAPACITY = ovls_pkg::CAPACITY_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ovls_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] value
    input  logic [ovls_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] status, [9:3] entry_count, [41:10] largest_value,
    // [73:42] second_value, [74] in_order
    output logic [ovls_pkg::M_TDATA_W-1:0] m_tdata
);
    import ovls_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic signed [VALUE_W-1:0] mem [CAPACITY];

    logic [1:0]                state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic [CNT_W-1:0]          rd_cnt_reg, rd_cnt_next;
    logic                      rd_vld_reg;
    logic [ADDR_W-1:0]         proc_idx_reg;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic [KIND_W-1:0]         kind_reg, kind_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [STATUS_W-1:0]       st_reg, st_next;
    logic                      found_reg, found_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]      m_tdata_reg, m_tdata_next;

    logic                      issue;
    logic                      we;
    logic [ADDR_W-1:0]         wa;
    logic signed [VALUE_W-1:0] wd;
    logic                      s_acc;
    logic [KIND_W-1:0]         s_kind;
    logic signed [VALUE_W-1:0] s_value;
    logic                      match;
    logic                      is_del;
    logic signed [VALUE_W-1:0] largest;
    logic signed [VALUE_W-1:0] second;

    cmp_ctl_t cmp_ctl;
    stats_t   stats;

    ovls_cmp_unit u_cmp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cmp_ctl),
        .stats   (stats)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign s_kind   = s_tuser[KIND_W-1:0];
    assign s_value  = s_tdata[VALUE_W-1:0];
    assign issue    = (state_reg == S_SCAN) && (rd_cnt_reg < n_reg);
    assign match    = (rd_data_reg == val_reg);
    assign is_del   = (kind_reg == KIND_DELETE);

    assign largest = (count_reg == '0) ? NEG_ONE : stats.top;
    assign second  = ((count_reg < CNT_W'(2)) || (stats.runner == INT_MIN))
                     ? NEG_ONE : stats.runner;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        rd_cnt_next   = rd_cnt_reg;
        kind_next     = kind_reg;
        val_next      = val_reg;
        st_next       = st_reg;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        we            = 1'b0;
        wa            = '0;
        wd            = s_value;
        cmp_ctl.clear = 1'b0;
        cmp_ctl.en    = 1'b0;
        cmp_ctl.data  = rd_data_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    kind_next     = s_kind;
                    val_next      = s_value;
                    found_next    = 1'b0;
                    rd_cnt_next   = '0;
                    cmp_ctl.clear = 1'b1;
                    n_next        = count_reg;
                    state_next    = S_SCAN;
                    if (s_kind == KIND_INSERT) begin
                        if (count_reg >= CNT_W'(CAPACITY)) begin
                            st_next = ST_FULL;
                        end else begin
                            we         = 1'b1;
                            wa         = count_reg[ADDR_W-1:0];
                            count_next = count_reg + 1'b1;
                            n_next     = count_reg + 1'b1;
                            st_next    = ST_INSERTED;
                        end
                    end else if (count_reg == '0) begin
                        st_next    = ST_EMPTY;
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (issue) begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    if (is_del && found_reg) begin
                        // close the gap behind the deleted entry
                        we         = 1'b1;
                        wa         = proc_idx_reg - 1'b1;
                        wd         = rd_data_reg;
                        cmp_ctl.en = 1'b1;
                    end else if (match && !found_reg) begin
                        found_next = 1'b1;
                        cmp_ctl.en = !is_del;
                    end else begin
                        cmp_ctl.en = 1'b1;
                    end
                end
                if (!issue && !rd_vld_reg) begin
                    state_next = S_DONE;
                    if (is_del) begin
                        st_next = found_reg ? ST_DELETED : ST_NOT_FOUND;
                        if (found_reg) begin
                            count_next = count_reg - 1'b1;
                        end
                    end else if (kind_reg != KIND_INSERT) begin
                        st_next = found_reg ? ST_FOUND : ST_NOT_FOUND;
                    end
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({stats.sorted, second, largest,
                                                COUNT_W'(count_reg), st_reg});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_data_reg  <= mem[rd_cnt_reg[ADDR_W-1:0]];
        proc_idx_reg <= rd_cnt_reg[ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_cnt_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_cnt_reg   <= rd_cnt_next;
            rd_vld_reg   <= issue;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        n_reg       <= n_next;
        kind_reg    <= kind_next;
        val_reg     <= val_next;
        st_reg      <= st_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
